FILE: rtl/core/u8tfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8tfc_pkg
// Types, letter table and lookup helpers for the utf-8 turkish transcoder.
// ----------------------------------------------------------------------------
package u8tfc_pkg;

    localparam int NumLetters = 12;

    localparam logic [7:0] LeadC3 = 8'hC3;
    localparam logic [7:0] LeadC4 = 8'hC4;
    localparam logic [7:0] LeadC5 = 8'hC5;

    // one row of the letter table
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] tail;
        logic [7:0] code_iso;
        logic [7:0] code_small;
    } letter_t;

    // one result item as it sits in the output queue
    typedef struct packed {
        logic [7:0] code;
        logic       eot;
        logic       last;
    } result_t;

    // outcome of a pair lookup
    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } lookup_t;

    localparam letter_t Letters [NumLetters] = '{
        '{8'hC3, 8'hA7, 8'hE7, 8'h80},
        '{8'hC3, 8'h87, 8'hC7, 8'h81},
        '{8'hC3, 8'hB6, 8'hF6, 8'h82},
        '{8'hC3, 8'h96, 8'hD6, 8'h83},
        '{8'hC3, 8'hBC, 8'hFC, 8'h84},
        '{8'hC3, 8'h9C, 8'hDC, 8'h85},
        '{8'hC4, 8'hB1, 8'h1A, 8'h86},
        '{8'hC4, 8'hB0, 8'h1B, 8'h87},
        '{8'hC4, 8'h9F, 8'h1C, 8'h88},
        '{8'hC4, 8'h9E, 8'h1D, 8'h89},
        '{8'hC5, 8'h9F, 8'h1E, 8'h8A},
        '{8'hC5, 8'h9E, 8'h1F, 8'h8B}
    };

    // lead byte of a two-byte turkish letter
    function automatic logic is_lead(input logic [7:0] b);
        return (b == LeadC3) || (b == LeadC4) || (b == LeadC5);
    endfunction

    // match a lead/tail pair against the table, independent compares
    function automatic lookup_t find_letter(input logic [7:0] lead,
                                            input logic [7:0] tail,
                                            input logic       iso);
        lookup_t r;
        r.hit  = 1'b0;
        r.code = 8'h00;
        for (int k = 0; k < NumLetters; k++)
        begin
            if ((Letters[k].lead == lead) && (Letters[k].tail == tail))
            begin
                r.hit  = 1'b1;
                r.code = iso ? Letters[k].code_iso : Letters[k].code_small;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/utf8_turkish_to_font_code.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_turkish_to_font_code
// Turns two-byte utf-8 turkish letters into single font code bytes.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | byte_in[7:0], end_in
//  out     | out_valid/out_stall | char_out[7:0], end_of_text, last_of_item
//  cfg     | cfg_wr_en           | cfg_wr_data (font_mode_iso)
//
//  one item per cycle while in_stall is low: input register, lookup logic,
//  two-entry result queue. an item giving two results leaves as two queue
//  entries, one after the other, through the single read port of the queue.
//  reset clears the input stage, held lead, queue count and sets iso mode.
//  in_stall rises when the queue cannot take the results of the item in
//  the input register after this cycle's pop.
// ----------------------------------------------------------------------------
module utf8_turkish_to_font_code (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] byte_in,
    input  wire logic       end_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      char_out,
    output logic            end_of_text,
    output logic            last_of_item,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data
);

    logic       mode_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_lead_reg, held_lead_next;
    logic [1:0] cnt_reg, cnt_next;
    u8tfc_pkg::result_t ent0_reg, ent0_next;
    u8tfc_pkg::result_t ent1_reg, ent1_next;

    u8tfc_pkg::lookup_t lk;
    u8tfc_pkg::result_t r0, r1;
    logic [1:0] n_res;
    logic       hold_new;
    logic       fresh_hold;
    logic       accept;
    logic       advance;
    logic       pop;
    logic [1:0] cnt_p;
    logic [2:0] fill_sum;
    u8tfc_pkg::result_t s0, s1;

    // result decode for the item in the input register
    always_comb
    begin
        lk         = u8tfc_pkg::find_letter(held_lead_reg, in_byte_reg, mode_reg);
        fresh_hold = u8tfc_pkg::is_lead(in_byte_reg) && !in_end_reg;
        r0         = '0;
        r1         = '0;
        n_res      = 2'd0;
        hold_new   = 1'b0;
        if (held_valid_reg)
        begin
            if (lk.hit)
            begin
                r0    = '{code: lk.code, eot: in_end_reg, last: 1'b1};
                n_res = 2'd1;
            end
            else if (fresh_hold)
            begin
                r0       = '{code: held_lead_reg, eot: 1'b0, last: 1'b1};
                n_res    = 2'd1;
                hold_new = 1'b1;
            end
            else
            begin
                r0    = '{code: held_lead_reg, eot: 1'b0, last: 1'b0};
                r1    = '{code: in_byte_reg, eot: in_end_reg, last: 1'b1};
                n_res = 2'd2;
            end
        end
        else if (fresh_hold)
        begin
            hold_new = 1'b1;
        end
        else
        begin
            r0    = '{code: in_byte_reg, eot: in_end_reg, last: 1'b1};
            n_res = 2'd1;
        end
    end

    // queue room check and input handshake
    assign pop      = (cnt_reg != 2'd0) && !out_stall;
    assign cnt_p    = cnt_reg - {1'b0, pop};
    assign fill_sum = {1'b0, cnt_p} + {1'b0, n_res};
    assign advance  = in_valid_reg && (fill_sum <= 3'd2);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // input stage and held lead
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        held_valid_next = held_valid_reg;
        held_lead_next  = held_lead_reg;
        if (advance)
        begin
            in_valid_next   = 1'b0;
            held_valid_next = hold_new;
            held_lead_next  = hold_new ? in_byte_reg : 8'h00;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    // result queue: pop shifts down, push fills behind what remains
    always_comb
    begin
        s0        = pop ? ent1_reg : ent0_reg;
        s1        = ent1_reg;
        ent0_next = s0;
        ent1_next = s1;
        cnt_next  = cnt_p;
        if (advance)
        begin
            cnt_next = fill_sum[1:0];
            case (cnt_p)
                2'd0:
                begin
                    ent0_next = r0;
                    ent1_next = r1;
                end
                2'd1:
                begin
                    ent1_next = r0;
                end
                default:
                begin
                    ent0_next = s0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b1;
            in_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_lead_reg  <= 8'h00;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            in_valid_reg   <= in_valid_next;
            held_valid_reg <= held_valid_next;
            held_lead_reg  <= held_lead_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_in;
            in_end_reg  <= end_in;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    // output port
    assign out_valid    = (cnt_reg != 2'd0);
    assign char_out     = ent0_reg.code;
    assign end_of_text  = ent0_reg.eot;
    assign last_of_item = ent0_reg.last;

endmodule
`default_nettype wire

FILE: rtl/core/u8tfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8tfc_checker
// Port-level checks for the utf-8 turkish transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8tfc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] char_out,
    input wire logic       end_of_text,
    input wire logic       last_of_item
);

    // stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out)
            && $stable(end_of_text) && $stable(last_of_item))
        else $error("stalled result item changed");

    // second result of an item is already queued behind the first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_item |=> out_valid)
        else $error("second result of item missing");

    // end of text only on the last result of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> last_of_item)
        else $error("end of text on a non-final result");

    // nothing shown while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result item during reset");

endmodule

bind utf8_turkish_to_font_code u8tfc_checker u_chk (.*);
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the utf-8 turkish letter transcoder against a cycle-free predictor.
// A queue of text bytes and mode writes feeds a clocked driver. A clocked
// monitor takes results under random stall and compares every field with
// the oldest predicted font code. The mode register changes only when idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned MaxWait = 12;
    localparam int unsigned PhaseItems = 146;

    // one entry of the stimulus queue: a text byte or a mode write
    typedef struct packed {
        logic       is_cfg;
        logic [7:0] b;
        logic       fin;
        logic       mode;
    } text_item_t;

    // one predicted output byte
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       last;
    } font_code_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in = 8'h00;
    logic       end_in = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_out;
    logic       end_of_text;
    logic       last_of_item;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;

    text_item_t  text_q [$];
    font_code_t  font_code_q [$];
    int unsigned err_count = 0;
    int unsigned cycle_cnt = 0;

    // predictor state
    logic [7:0] held_byte = 8'h00;
    logic       lead_held = 1'b0;
    logic       font_iso = 1'b1;

    // driver and monitor bookkeeping
    text_item_t  drv_item;
    logic        drv_fire;
    logic        drv_load;
    logic        drv_cfg;
    logic        drv_calm = 1'b0;
    int unsigned drv_gap = 0;
    int unsigned idle_cnt = 0;
    font_code_t  mon_want;
    logic        mon_calm = 1'b0;
    int unsigned mon_gap = 0;

    utf8_turkish_to_font_code u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .end_in       (end_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .end_of_text  (end_of_text),
        .last_of_item (last_of_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // letter table: {lead, tail, iso code, small code}
    function automatic logic [31:0] glyph_entry(input int unsigned k);
        case (k)
            0:       return 32'hC3A7_E780;
            1:       return 32'hC387_C781;
            2:       return 32'hC3B6_F682;
            3:       return 32'hC396_D683;
            4:       return 32'hC3BC_FC84;
            5:       return 32'hC39C_DC85;
            6:       return 32'hC4B1_1A86;
            7:       return 32'hC4B0_1B87;
            8:       return 32'hC49F_1C88;
            9:       return 32'hC49E_1D89;
            10:      return 32'hC59F_1E8A;
            11:      return 32'hC59E_1F8B;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // wait before the next item or result, with stretches of no waiting
    function automatic int unsigned draw_wait(input logic calm);
        if (calm)
            return 0;
        return $urandom_range(0, MaxWait);
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 100)
            $display("[cycle %0d] mismatch: %s", cycle_cnt, what);
    endtask

    // expected output bytes for one accepted text byte
    task automatic predict_font_codes(input logic [7:0] b, input logic fin);
        logic [7:0]  outs [2];
        logic [31:0] row;
        int unsigned n;
        logic        fresh;
        n = 0;
        fresh = 1'b1;
        if (lead_held)
        begin
            lead_held = 1'b0;
            outs[0] = held_byte;
            for (int unsigned k = 0; k < u8tfc_pkg::NumLetters; k++)
            begin
                row = glyph_entry(k);
                if (row[31:16] == {held_byte, b})
                begin
                    outs[0] = font_iso ? row[15:8] : row[7:0];
                    fresh = 1'b0;
                end
            end
            n = 1;
            held_byte = 8'h00;
        end
        if (fresh)
        begin
            if ((b == u8tfc_pkg::LeadC3 || b == u8tfc_pkg::LeadC4 ||
                 b == u8tfc_pkg::LeadC5) && !fin)
            begin
                held_byte = b;
                lead_held = 1'b1;
            end
            else
            begin
                outs[n] = b;
                n++;
            end
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            font_code_q.push_back('{ch: outs[k], eot: fin && (k == n - 1),
                                    last: (k == n - 1)});
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        text_q.push_back('{is_cfg: 1'b0, b: b, fin: fin, mode: 1'b0});
    endtask

    task automatic push_mode(input logic mode);
        text_q.push_back('{is_cfg: 1'b1, b: 8'h00, fin: 1'b0, mode: mode});
    endtask

    // random text byte, now and then the final one
    task automatic push_any(input logic [7:0] b);
        push_byte(b, $urandom_range(0, 9) == 0);
    endtask

    // random text: mostly letters and plain text, some noise and broken pairs
    task automatic add_random_text(input int unsigned n_items);
        int unsigned added;
        int unsigned pick;
        logic [31:0] row;
        added = 0;
        while (added < n_items)
        begin
            pick = $urandom_range(0, 99);
            row = glyph_entry($urandom_range(0, u8tfc_pkg::NumLetters - 1));
            if (pick < 40)
            begin
                push_any(row[31:24]);
                push_any(row[23:16]);
                added += 2;
            end
            else if (pick < 65)
            begin
                push_any(8'($urandom_range(32, 126)));
                added++;
            end
            else if (pick < 80)
            begin
                push_any(8'($urandom));
                added++;
            end
            else if (pick < 90)
            begin
                // lead with a wrong or borrowed tail
                push_any(u8tfc_pkg::LeadC3 + 8'($urandom_range(0, 2)));
                push_any($urandom_range(0, 1) ? row[23:16] : 8'($urandom));
                added += 2;
            end
            else
            begin
                // lead followed by another lead
                push_any(u8tfc_pkg::LeadC3 + 8'($urandom_range(0, 2)));
                push_any(u8tfc_pkg::LeadC3 + 8'($urandom_range(0, 2)));
                added += 2;
            end
        end
    endtask

    // driver: presents text bytes, holds them under stall, writes the mode when idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            byte_in <= 8'h00;
            end_in <= 1'b0;
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= 1'b0;
            held_byte = 8'h00;
            lead_held = 1'b0;
            font_iso = 1'b1;
            drv_gap = 0;
            idle_cnt = 0;
        end
        else
        begin
            drv_fire = in_valid && !in_stall;
            drv_load = 1'b0;
            drv_cfg = 1'b0;
            if (drv_fire)
                predict_font_codes(byte_in, end_in);

            // idle means nothing offered and nothing outstanding
            if (!in_valid && font_code_q.size() == 0)
                idle_cnt = (idle_cnt < SettleCycles) ? idle_cnt + 1 : idle_cnt;
            else
                idle_cnt = 0;

            if (in_valid && !drv_fire)
            begin
                // stalled: hold the item
            end
            else if (drv_gap != 0)
                drv_gap--;
            else if (text_q.size() != 0)
            begin
                if (!text_q[0].is_cfg)
                begin
                    drv_item = text_q.pop_front();
                    drv_load = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        drv_calm = !drv_calm;
                    drv_gap = draw_wait(drv_calm);
                end
                else if (!in_valid && idle_cnt >= SettleCycles)
                begin
                    drv_item = text_q.pop_front();
                    drv_cfg = 1'b1;
                    font_iso = drv_item.mode;
                end
            end

            in_valid <= (in_valid && !drv_fire) || drv_load;
            if (drv_load)
            begin
                byte_in <= drv_item.b;
                end_in <= drv_item.fin;
            end
            cfg_wr_en <= drv_cfg;
            if (drv_cfg)
                cfg_wr_data <= drv_item.mode;
        end
    end

    // monitor: random stall, compares each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mon_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (font_code_q.size() == 0)
                    report_mismatch($sformatf("unexpected result char_out=%02h", char_out));
                else
                begin
                    mon_want = font_code_q.pop_front();
                    if (char_out !== mon_want.ch)
                        report_mismatch($sformatf("char_out got %02h want %02h",
                                                  char_out, mon_want.ch));
                    if (end_of_text !== mon_want.eot)
                        report_mismatch($sformatf("end_of_text got %b want %b",
                                                  end_of_text, mon_want.eot));
                    if (last_of_item !== mon_want.last)
                        report_mismatch($sformatf("last_of_item got %b want %b",
                                                  last_of_item, mon_want.last));
                end
                if ($urandom_range(0, 39) == 0)
                    mon_calm = !mon_calm;
                mon_gap = draw_wait(mon_calm);
            end
            else if (mon_gap != 0)
                mon_gap--;
            out_stall <= (mon_gap != 0);
        end
    end

    // run limit
    initial
    begin
        wait (cycle_cnt == CycleLimit);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        // directed: extremes, matches, broken pairs, final-position leads
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA7, 1'b0);
        push_byte(8'hC4, 1'b0);
        push_byte(8'hB1, 1'b0);
        push_byte(8'hC5, 1'b0);
        push_byte(8'h9E, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hC4, 1'b0);
        push_byte(8'hC5, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'hC5, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h87, 1'b1);
        push_byte(8'hC4, 1'b0);
        push_byte(8'h55, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hC4, 1'b1);
        push_mode(1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h9C, 1'b0);
        push_byte(8'hC5, 1'b0);
        push_byte(8'h9F, 1'b1);

        // random phases, mode flips between them
        for (int unsigned p = 0; p < 5; p++)
        begin
            push_mode((p < 4) ? 1'(p % 2 == 0) : 1'($urandom_range(0, 1)));
            add_random_text(PhaseItems);
        end
        push_byte(8'h0A, 1'b1);

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || in_valid)
            @(posedge clk);
        while (font_code_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: utf8_turkish_to_font_code.f
rtl/core/u8tfc_pkg.sv
rtl/core/utf8_turkish_to_font_code.sv
rtl/core/u8tfc_checker.sv
dv/testbench.sv
